@@ sv/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg: shared types and codes of the bitmap page allocator
// Request and response layouts, operation, status and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

   localparam int MAX_PAGES_DEF     = 65536;
   localparam int MAP_WORD_BITS_DEF = 64;

   localparam int CNT_W     = 17;
   localparam int PAGE_W    = 16;
   localparam int FUNC_W    = 3;
   localparam int STAT_W    = 3;
   localparam int CSR_IDX_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_ADD     = 3'd0;
   localparam logic [FUNC_W-1:0] FN_RESERVE = 3'd1;
   localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd2;
   localparam logic [FUNC_W-1:0] FN_FREE    = 3'd3;
   localparam logic [FUNC_W-1:0] FN_OPEN    = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_OPEN  = 3'd1;
   localparam logic [STAT_W-1:0] ST_ZERO      = 3'd2;
   localparam logic [STAT_W-1:0] ST_FEW_FREE  = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_RUN    = 3'd4;
   localparam logic [STAT_W-1:0] ST_BAD_RANGE = 3'd5;
   localparam logic [STAT_W-1:0] ST_REFUSED   = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MANAGED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_META_FIRST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_META_TOTAL = 2'd2;

   localparam logic [CNT_W-1:0] MANAGED_RESET = 17'h10000;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PAGE_W-1:0] start_page;
      logic [CNT_W-1:0]  page_total;
      logic [CNT_W-1:0]  align_pages;
      logic              limit_on;
      logic [PAGE_W-1:0] limit_page;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [STAT_W-1:0] status;
      logic [PAGE_W-1:0] result_page;
      logic [CNT_W-1:0]  free_total;
      logic [CNT_W-1:0]  pinned_total;
      logic [CNT_W-1:0]  usable_total;
   } rsp_type;

endpackage

`default_nettype wire

@@ sv/bpa_map_ram.sv @@
// ----------------------------------------------------------------------------
// bpa_map_ram: page bitmap store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_map_ram #(
   parameter int DEPTH = 1024,
   parameter int DW    = 192,
   parameter int AD    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AD-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AD-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ sv/bpa_rem_unit.sv @@
// ----------------------------------------------------------------------------
// bpa_rem_unit: serial remainder
// Restoring division, one numerator bit per cycle; returns num % den.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_rem_unit #(
   parameter int NW = 19,
   parameter int DW = 17
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          go,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic      [DW-1:0] rem
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, num_ff[NW-1]};
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in the next bit, subtract when it fits
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DW-1:0];
         end
         num_in = {num_ff[NW-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

@@ sv/bitmap_page_allocator_core.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core: next-fit bitmap page allocator
// Usable, used and pinned page maps in one word-wide memory, swept one map
// word per cycle by a sequencer; counters and the next-fit hint in registers.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+---------------------------------
//  request  | start, busy, req_data          | taken when start=1 and busy=0
//  response | rsp_valid, rsp_data            | one-cycle strobe, cannot stall
//  config   | csr_valid, csr_ready,          | write when csr_valid=1 and
//           | csr_index, csr_wdata           | csr_ready=1 (always ready)
//
// Each request gives exactly one response. Open requests and requests
//   rejected on acceptance go straight to the response; add-usable, reserve
//   and free sweep the map words of their range (free sweeps its range
//   twice, checking it first). Alloc scans map words, up to MAP_WORDS per
//   pass, and runs the serial remainder each time the run start must be
//   realigned (never when the alignment is 1).
// Reset: synchronous; afterwards all MAP_WORDS map words (1024 by default)
//   are cleared one word a cycle with busy high. Config writes are taken
//   throughout.
// Stalls: none on the response side; busy stays high until the response
//   strobe is issued and is low while the strobe is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator_core #(
   parameter int MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
   parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire bpa_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   output bpa_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [bpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bpa_pkg::CNT_W-1:0]          csr_wdata
);

   import bpa_pkg::*;

   // word width must be a power of two, not checked here: page to word is a shift
   localparam int W         = MAP_WORD_BITS;
   localparam int WB        = $clog2(W);
   localparam int MAP_WORDS = (MAX_PAGES + W - 1) / W;
   localparam int AD        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PB        = $clog2(MAX_PAGES + 1);
   localparam int AW        = ((PB > CNT_W) ? PB : CNT_W) + 2;
   localparam int MW        = 3 * W;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_SWEEP = 9'b000000100,
      S_CHECK = 9'b000001000,
      S_SRCH  = 9'b000010000,
      S_ALGN  = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_BOUND = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   // bit i set when lo <= base+i < hi
   function automatic logic [W-1:0] range_bits(input logic [AW-1:0] base,
                                                input logic [AW-1:0] lo,
                                                input logic [AW-1:0] hi);
      logic [W-1:0]  m;
      logic [AW-1:0] pg;
      m = '0;
      for (int i = 0; i < W; i++) begin
         pg   = base + AW'(i);
         m[i] = (pg >= lo) && (pg < hi);
      end
      return m;
   endfunction

   function automatic logic [WB:0] popc(input logic [W-1:0] v);
      logic [WB:0] s;
      s = '0;
      for (int i = 0; i < W; i++) begin
         s = s + (WB+1)'(v[i]);
      end
      return s;
   endfunction

   function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
                                                input logic [WB:0] k);
      logic [CNT_W-1:0] kk;
      kk = CNT_W'(k);
      return (a > kk) ? a - kk : '0;
   endfunction

   // -------------------------------------------------------------------------
   // registers
   // -------------------------------------------------------------------------
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  managed_ff, managed_in;
   logic [PAGE_W-1:0] meta_first_ff, meta_first_in;
   logic [CNT_W-1:0]  meta_total_ff, meta_total_in;
   logic [CNT_W-1:0]  free_ff, free_in;
   logic [CNT_W-1:0]  pin_ff, pin_in;
   logic [CNT_W-1:0]  usable_ff, usable_in;
   logic [AW-1:0]     hint_ff, hint_in;
   logic              opened_ff, opened_in;
   logic [FUNC_W-1:0] op_ff, op_in;
   logic [AW-1:0]     lo_ff, lo_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]  align_ff, align_in;
   logic              lim_on_ff, lim_on_in;
   logic [AW-1:0]     lim_ff, lim_in;
   logic [AW-1:0]     cand_ff, cand_in;
   logic [AW-1:0]     newp_ff, newp_in;
   logic              pass_ff, pass_in;
   logic [AD-1:0]     cur_ff, cur_in;
   logic [AD-1:0]     last_ff, last_in;
   logic [AD-1:0]     clr_ff, clr_in;
   logic [PAGE_W-1:0] res_ff, res_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // memory and remainder unit
   logic          ram_we, ram_re;
   logic [AD-1:0] ram_wa, ram_ra;
   logic [MW-1:0] ram_wd, ram_rd;
   logic          div_go, div_done;
   logic [CNT_W-1:0] div_rem;

   bpa_map_ram #(.DEPTH(MAP_WORDS), .DW(MW), .AD(AD)) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   bpa_rem_unit #(.NW(AW), .DW(CNT_W)) u_rem (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (newp_ff),
      .den   (align_ff),
      .done  (div_done),
      .rem   (div_rem)
   );

   // -------------------------------------------------------------------------
   // combinational helpers
   // -------------------------------------------------------------------------
   logic [AW-1:0] pc, st, ct, base, mlo, mhi, rng_end, runend, endp, badp;
   logic [W-1:0]  w_usable, w_used, w_pinned, m_rng, m_meta, m_cons, m_pc;
   logic [W-1:0]  add_new, u_rng, res_pin, set_used, clr_used, chk_bad, srch_bad;
   logic [WB-1:0] bad_idx;
   logic [CNT_W-1:0] req_align;

   always_comb begin
      pc = (AW'(managed_ff) > AW'(MAX_PAGES)) ? AW'(MAX_PAGES) : AW'(managed_ff);
      st = AW'(req_data.start_page);
      ct = AW'(req_data.page_total);
      req_align = (req_data.align_pages == '0) ? CNT_W'(1) : req_data.align_pages;
      rng_end = (st + ct < pc) ? st + ct : pc;
      base = {{(AW-AD-WB){1'b0}}, cur_ff, {WB{1'b0}}};
      mlo  = AW'(meta_first_ff);
      mhi  = AW'(meta_first_ff) + AW'(meta_total_ff);

      w_usable = ram_rd[W-1:0];
      w_used   = ram_rd[2*W-1:W];
      w_pinned = ram_rd[3*W-1:2*W];

      m_rng    = range_bits(base, lo_ff, hi_ff);
      m_meta   = range_bits(base, mlo, mhi);
      m_cons   = range_bits(base, cand_ff, base + AW'(W));
      m_pc     = range_bits(base, '0, pc);

      add_new  = m_rng & ~w_usable;
      u_rng    = m_rng & w_usable;
      res_pin  = u_rng & ~w_pinned;
      set_used = u_rng & ~w_used;
      clr_used = u_rng & w_used;
      chk_bad  = m_rng & (~w_usable | w_pinned | m_meta | ~w_used);
      srch_bad = m_cons & ~(w_usable & ~w_used & ~w_pinned & m_pc);

      // lowest page that breaks the run
      bad_idx = '0;
      for (int i = W - 1; i >= 0; i--) begin
         if (srch_bad[i]) begin
            bad_idx = WB'(i);
         end
      end
      badp   = base + AW'(bad_idx);
      runend = cand_ff + cnt_ff;
      // second pass must end before the hint
      endp   = pass_ff ? ((hint_ff < pc) ? hint_ff : pc) : pc;
   end

   // -------------------------------------------------------------------------
   // sequencer
   // -------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      managed_in    = managed_ff;
      meta_first_in = meta_first_ff;
      meta_total_in = meta_total_ff;
      free_in       = free_ff;
      pin_in        = pin_ff;
      usable_in     = usable_ff;
      hint_in       = hint_ff;
      opened_in     = opened_ff;
      op_in         = op_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cnt_in        = cnt_ff;
      align_in      = align_ff;
      lim_on_in     = lim_on_ff;
      lim_in        = lim_ff;
      cand_in       = cand_ff;
      newp_in       = newp_ff;
      pass_in       = pass_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      clr_in        = clr_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_wa        = cur_ff;
      ram_wd        = ram_rd;
      ram_re        = 1'b0;
      ram_ra        = cur_ff + AD'(1);
      div_go        = 1'b0;

      // configuration writes, taken in any state
      if (csr_valid) begin
         case (csr_index)
            CSR_MANAGED:    managed_in    = csr_wdata;
            CSR_META_FIRST: meta_first_in = csr_wdata[PAGE_W-1:0];
            CSR_META_TOTAL: meta_total_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            // used all ones, usable and pinned clear
            ram_we = 1'b1;
            ram_wa = clr_ff;
            ram_wd = {{W{1'b0}}, {W{1'b1}}, {W{1'b0}}};
            clr_in = clr_ff + AD'(1);
            if (clr_ff == AD'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               op_in     = req_data.func;
               status_in = ST_OK;
               res_in    = '0;
               state_in  = S_DONE;
               case (req_data.func)
                  FN_ADD, FN_RESERVE: begin
                     if (req_data.func == FN_ADD && opened_ff) begin
                        status_in = ST_BAD_RANGE;
                     end else if (req_data.func == FN_RESERVE && !opened_ff) begin
                        status_in = ST_NOT_OPEN;
                     end else if (ct == '0) begin
                        status_in = ST_ZERO;
                     end else if (st < rng_end) begin
                        lo_in    = st;
                        hi_in    = rng_end;
                        cur_in   = st[WB +: AD];
                        last_in  = AD'((rng_end - AW'(1)) >> WB);
                        ram_re   = 1'b1;
                        ram_ra   = st[WB +: AD];
                        state_in = S_SWEEP;
                     end
                  end
                  FN_ALLOC: begin
                     if (!opened_ff) begin
                        status_in = ST_NOT_OPEN;
                     end else if (ct == '0) begin
                        status_in = ST_ZERO;
                     end else if (ct > AW'(free_ff)) begin
                        status_in = ST_FEW_FREE;
                     end else begin
                        cnt_in    = ct;
                        align_in  = req_align;
                        lim_on_in = req_data.limit_on;
                        lim_in    = AW'(req_data.limit_page);
                        pass_in   = 1'b0;
                        cand_in   = hint_ff;
                        newp_in   = hint_ff;
                        state_in  = S_ALGN;
                     end
                  end
                  FN_FREE: begin
                     if (!opened_ff) begin
                        status_in = ST_NOT_OPEN;
                     end else if (ct == '0) begin
                        status_in = ST_ZERO;
                     end else if (st >= pc || ct > pc - st) begin
                        status_in = ST_BAD_RANGE;
                     end else begin
                        lo_in    = st;
                        hi_in    = st + ct;
                        cur_in   = st[WB +: AD];
                        last_in  = AD'((st + ct - AW'(1)) >> WB);
                        ram_re   = 1'b1;
                        ram_ra   = st[WB +: AD];
                        state_in = S_CHECK;
                     end
                  end
                  FN_OPEN: begin
                     hint_in   = (st < pc) ? st : '0;
                     opened_in = 1'b1;
                  end
                  default: status_in = ST_BAD_RANGE;
               endcase
            end
         end

         S_SWEEP: begin
            // modify the word that has just arrived and write it back
            ram_we = 1'b1;
            ram_wa = cur_ff;
            case (op_ff)
               FN_ADD: begin
                  ram_wd    = {w_pinned, w_used & ~add_new, w_usable | add_new};
                  usable_in = usable_ff + CNT_W'(popc(add_new));
                  free_in   = free_ff + CNT_W'(popc(add_new));
               end
               FN_RESERVE: begin
                  ram_wd  = {w_pinned | u_rng, w_used | u_rng, w_usable};
                  pin_in  = pin_ff + CNT_W'(popc(res_pin));
                  free_in = sat_sub(free_ff, popc(set_used));
               end
               FN_ALLOC: begin
                  ram_wd  = {w_pinned, w_used | u_rng, w_usable};
                  free_in = sat_sub(free_ff, popc(set_used));
               end
               FN_FREE: begin
                  ram_wd  = {w_pinned, w_used & ~u_rng, w_usable};
                  free_in = free_ff + CNT_W'(popc(clr_used));
               end
               default: ram_we = 1'b0;
            endcase
            if (cur_ff == last_ff) begin
               state_in = S_DONE;
               if (op_ff == FN_ALLOC) begin
                  hint_in = (hi_ff >= pc) ? '0 : hi_ff;
                  res_in  = lo_ff[PAGE_W-1:0];
               end else if (op_ff == FN_FREE && lo_ff < hint_ff) begin
                  hint_in = lo_ff;
               end
            end else begin
               ram_re = 1'b1;
               cur_in = cur_ff + AD'(1);
            end
         end

         S_CHECK: begin
            // first sweep of a free: any bad page refuses the whole range
            if (|chk_bad) begin
               status_in = ST_REFUSED;
               state_in  = S_DONE;
            end else if (cur_ff == last_ff) begin
               cur_in   = lo_ff[WB +: AD];
               ram_re   = 1'b1;
               ram_ra   = lo_ff[WB +: AD];
               state_in = S_SWEEP;
            end else begin
               ram_re = 1'b1;
               cur_in = cur_ff + AD'(1);
            end
         end

         S_SRCH: begin
            ram_re = 1'b1;
            if ((|srch_bad) && badp < runend) begin
               // run broken: restart after the bad page
               newp_in  = badp + AW'(1);
               cand_in  = badp + AW'(1);
               state_in = S_ALGN;
            end else if (runend <= base + AW'(W)) begin
               lo_in    = cand_ff;
               hi_in    = runend;
               cur_in   = cand_ff[WB +: AD];
               last_in  = AD'((runend - AW'(1)) >> WB);
               ram_ra   = cand_ff[WB +: AD];
               state_in = S_SWEEP;
            end else begin
               cur_in = cur_ff + AD'(1);
            end
         end

         S_ALGN: begin
            if (align_ff == CNT_W'(1)) begin
               state_in = S_BOUND;
            end else begin
               div_go   = 1'b1;
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            if (div_done) begin
               cand_in  = (div_rem == '0) ? newp_ff
                                          : newp_ff + AW'(align_ff) - AW'(div_rem);
               state_in = S_BOUND;
            end
         end

         S_BOUND: begin
            if (runend <= endp && (!lim_on_ff || runend - AW'(1) <= lim_ff)) begin
               cur_in   = cand_ff[WB +: AD];
               ram_re   = 1'b1;
               ram_ra   = cand_ff[WB +: AD];
               state_in = S_SRCH;
            end else if (!pass_ff) begin
               // wrap round: second pass from page 0
               pass_in = 1'b1;
               cand_in = '0;
            end else begin
               status_in = ST_NO_RUN;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            rsp_valid_in        = 1'b1;
            rsp_in.ok           = (status_ff == ST_OK);
            rsp_in.status       = status_ff;
            rsp_in.result_page  = res_ff;
            rsp_in.free_total   = free_ff;
            rsp_in.pinned_total = pin_ff;
            rsp_in.usable_total = usable_ff;
            state_in            = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         managed_ff    <= MANAGED_RESET;
         meta_first_ff <= '0;
         meta_total_ff <= '0;
         free_ff       <= '0;
         pin_ff        <= '0;
         usable_ff     <= '0;
         hint_ff       <= '0;
         opened_ff     <= 1'b0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         managed_ff    <= managed_in;
         meta_first_ff <= meta_first_in;
         meta_total_ff <= meta_total_in;
         free_ff       <= free_in;
         pin_ff        <= pin_in;
         usable_ff     <= usable_in;
         hint_ff       <= hint_in;
         opened_ff     <= opened_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff     <= op_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      cnt_ff    <= cnt_in;
      align_ff  <= align_in;
      lim_on_ff <= lim_on_in;
      lim_ff    <= lim_in;
      cand_ff   <= cand_in;
      newp_ff   <= newp_in;
      pass_ff   <= pass_in;
      cur_ff    <= cur_in;
      last_ff   <= last_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // -------------------------------------------------------------------------
   // checks
   // -------------------------------------------------------------------------
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid_ff)
      else $error("completion without response strobe");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we)
      else $error("map written while idle");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.ok == (rsp_ff.status == ST_OK)))
      else $error("ok flag disagrees with status");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("remainder returned outside alignment wait");

endmodule

`default_nettype wire
